// File: rtl/core/slx_pkg.sv
// Shared types, codes and character helpers for the source text lexer.
// No dependencies; all other files but slx_chan_if import this package.
`timescale 1ns / 1ps

package slx_pkg;

	localparam int KEYWORD_CHARS_DEF = 6;
	localparam int POSITION_BITS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF   = 4;
	localparam int FIELD_BITS        = 16;
	localparam int KEYWORD_COUNT     = 8;

	typedef enum logic [3:0] {
		MODE_IDLE,
		MODE_WORD,
		MODE_INT,
		MODE_FRAC,
		MODE_STRING,
		MODE_EQ,
		MODE_LT,
		MODE_AMP,
		MODE_HALT
	} mode_t;

	typedef enum logic [4:0] {
		K_INT    = 5'd0,
		K_ID     = 5'd1,
		K_NUM    = 5'd2,
		K_IF     = 5'd3,
		K_ELSE   = 5'd4,
		K_RETURN = 5'd5,
		K_ASSIGN = 5'd6,
		K_PLUS   = 5'd7,
		K_MINUS  = 5'd8,
		K_MUL    = 5'd9,
		K_DIV    = 5'd10,
		K_LPAREN = 5'd11,
		K_RPAREN = 5'd12,
		K_LBRACE = 5'd13,
		K_RBRACE = 5'd14,
		K_SEMI   = 5'd15,
		K_GT     = 5'd16,
		K_EOF    = 5'd17,
		K_FOR    = 5'd18,
		K_WHILE  = 5'd19,
		K_EQ     = 5'd20,
		K_LE     = 5'd21,
		K_AND    = 5'd22,
		K_FLOAT  = 5'd23,
		K_STRING = 5'd24
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE         = 2'd0,
		ERR_UNEXPECTED   = 2'd1,
		ERR_UNTERMINATED = 2'd2
	} err_t;

	typedef struct packed {
		kind_t                 kind;
		logic [FIELD_BITS-1:0] line;
		logic [FIELD_BITS-1:0] column;
		logic [FIELD_BITS-1:0] length;
		err_t                  err;
	} result_t;

	// All results caused by one input item; first is always used.
	typedef struct packed {
		result_t first;
		result_t second;
		logic    two;
	} bundle_t;

	typedef struct packed {
		logic not_full;
		logic not_empty;
	} q_status_t;

	typedef struct packed {
		logic  hit;
		kind_t kind;
	} op_t;

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_EQUALS  = 8'h3D;
	localparam logic [7:0] CH_LESS    = 8'h3C;

	// Keyword text, first character in the low byte.
	localparam logic [63:0] KW_TEXT [KEYWORD_COUNT] = '{
		64'h0000_0000_0074_6E69,  // int
		64'h0000_0000_0000_6669,  // if
		64'h0000_0000_6573_6C65,  // else
		64'h0000_6E72_7574_6572,  // return
		64'h0000_0000_0072_6F66,  // for
		64'h0000_0065_6C69_6877,  // while
		64'h0000_0074_616F_6C66,  // float
		64'h0000_676E_6972_7473   // string
	};

	localparam kind_t KW_KIND [KEYWORD_COUNT] = '{
		K_INT, K_IF, K_ELSE, K_RETURN, K_FOR, K_WHILE, K_FLOAT, K_STRING
	};

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	function automatic op_t single_op(input logic [7:0] c);
		op_t r;
		r.hit  = 1'b1;
		r.kind = K_PLUS;
		case (c)
			8'h2B: r.kind = K_PLUS;
			8'h2D: r.kind = K_MINUS;
			8'h2A: r.kind = K_MUL;
			8'h2F: r.kind = K_DIV;
			8'h28: r.kind = K_LPAREN;
			8'h29: r.kind = K_RPAREN;
			8'h7B: r.kind = K_LBRACE;
			8'h7D: r.kind = K_RBRACE;
			8'h3B: r.kind = K_SEMI;
			8'h3E: r.kind = K_GT;
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/core/slx_chan_if.sv
// Valid/ready channel interfaces for the lexer: character input and token output.
// Standalone; no package needed.
`timescale 1ns / 1ps

interface slx_in_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] char_byte;

	modport source (output valid, req_type, char_byte, input ready);
	modport sink   (input valid, req_type, char_byte, output ready);
endinterface

interface slx_out_if;
	logic        valid;
	logic        ready;
	logic [4:0]  token_kind;
	logic [15:0] start_line;
	logic [15:0] start_column;
	logic [15:0] token_length;
	logic [1:0]  error_code;
	logic        last_of_run;

	modport source (output valid, token_kind, start_line, start_column, token_length,
		error_code, last_of_run, input ready);
	modport sink   (input valid, token_kind, start_line, start_column, token_length,
		error_code, last_of_run, output ready);
endinterface

// File: rtl/core/slx_front.sv
// Lexer front end: takes one character per transfer, tracks position and token state,
// and hands the results of each character to the queue. Uses slx_pkg and slx_in_if.
`timescale 1ns / 1ps

module slx_front #(
	parameter int KEYWORD_CHARS = slx_pkg::KEYWORD_CHARS_DEF,
	parameter int POSITION_BITS = slx_pkg::POSITION_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	slx_in_if.sink            char_in,
	input  slx_pkg::q_status_t q_status,
	output logic              push_valid,
	output slx_pkg::bundle_t  push_data
);
	import slx_pkg::*;

	localparam int PB = POSITION_BITS;
	localparam int WW = 8 * KEYWORD_CHARS;
	localparam logic [PB-1:0] POS_ONE = PB'(1);
	localparam logic [PB-1:0] POS_TWO = PB'(2);

	mode_t          mode_q, mode_d;
	logic [WW-1:0]  prefix_q, prefix_d;
	logic           too_long_q, too_long_d;
	logic [PB-1:0]  tsl_q, tsl_d, tsc_q, tsc_d, tcnt_q, tcnt_d;
	logic [PB-1:0]  line_q, line_d, col_q, col_d;
	logic           accept;
	kind_t          word_kind;
	logic           pend_v, new_v, done, halt_now, eof_reset;
	result_t        pend_r, new_r;
	logic [7:0]     c;
	op_t            op;

	function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
		return (v == {PB{1'b1}}) ? v : v + POS_ONE;
	endfunction

	function automatic result_t mk(input kind_t k, input logic [PB-1:0] ln,
		input logic [PB-1:0] col, input logic [PB-1:0] len, input err_t e);
		result_t r;
		r.kind   = k;
		r.line   = FIELD_BITS'(ln);
		r.column = FIELD_BITS'(col);
		r.length = FIELD_BITS'(len);
		r.err    = e;
		return r;
	endfunction

	assign char_in.ready = q_status.not_full;
	assign accept        = char_in.valid && char_in.ready;
	assign c             = char_in.char_byte;
	assign op            = single_op(c);

	// Keyword match on the stored word prefix.
	always_comb begin
		word_kind = K_ID;
		if (!too_long_q) begin
			for (int i = 0; i < KEYWORD_COUNT; i++) begin
				if (64'(prefix_q) == KW_TEXT[i]) word_kind = KW_KIND[i];
			end
		end
	end

	always_comb begin
		mode_d     = mode_q;
		prefix_d   = prefix_q;
		too_long_d = too_long_q;
		tsl_d      = tsl_q;
		tsc_d      = tsc_q;
		tcnt_d     = tcnt_q;
		line_d     = line_q;
		col_d      = col_q;
		pend_v     = 1'b0;
		pend_r     = '0;
		new_v      = 1'b0;
		new_r      = '0;
		done       = 1'b0;
		halt_now   = 1'b0;
		eof_reset  = 1'b0;

		if (mode_q != MODE_HALT) begin
			if (char_in.req_type) begin
				// End of source: flush, EOF, reset; open string or '&': error, halt.
				case (mode_q)
					MODE_WORD: begin
						pend_v = 1'b1;
						pend_r = mk(word_kind, tsl_q, tsc_q, tcnt_q, ERR_NONE);
					end
					MODE_INT, MODE_FRAC: begin
						pend_v = 1'b1;
						pend_r = mk(K_NUM, tsl_q, tsc_q, tcnt_q, ERR_NONE);
					end
					MODE_EQ: begin
						pend_v = 1'b1;
						pend_r = mk(K_ASSIGN, tsl_q, tsc_q, POS_ONE, ERR_NONE);
					end
					MODE_LT: begin
						pend_v = 1'b1;
						pend_r = mk(K_LE, tsl_q, tsc_q, POS_ONE, ERR_NONE);
					end
					MODE_AMP: begin
						pend_v   = 1'b1;
						pend_r   = mk(K_INT, tsl_q, tsc_q, '0, ERR_UNEXPECTED);
						halt_now = 1'b1;
					end
					MODE_STRING: begin
						pend_v   = 1'b1;
						pend_r   = mk(K_INT, tsl_q, tsc_q, '0, ERR_UNTERMINATED);
						halt_now = 1'b1;
					end
					default: ;
				endcase
				if (!halt_now) begin
					new_v     = 1'b1;
					new_r     = mk(K_EOF, line_q, col_q, '0, ERR_NONE);
					eof_reset = 1'b1;
				end
			end else begin
				case (mode_q)
					MODE_WORD: begin
						if (is_alpha(c) || is_digit(c)) begin
							if (tcnt_q >= PB'(KEYWORD_CHARS)) too_long_d = 1'b1;
							for (int i = 0; i < KEYWORD_CHARS; i++) begin
								if (tcnt_q == PB'(i)) prefix_d[8*i +: 8] = c;
							end
							tcnt_d = sat_inc(tcnt_q);
							done   = 1'b1;
						end else begin
							pend_v = 1'b1;
							pend_r = mk(word_kind, tsl_q, tsc_q, tcnt_q, ERR_NONE);
							mode_d = MODE_IDLE;
						end
					end
					MODE_INT: begin
						if (is_digit(c)) begin
							tcnt_d = sat_inc(tcnt_q);
							done   = 1'b1;
						end else if (c == CH_DOT) begin
							tcnt_d = sat_inc(tcnt_q);
							mode_d = MODE_FRAC;
							done   = 1'b1;
						end else begin
							pend_v = 1'b1;
							pend_r = mk(K_NUM, tsl_q, tsc_q, tcnt_q, ERR_NONE);
							mode_d = MODE_IDLE;
						end
					end
					MODE_FRAC: begin
						if (is_digit(c)) begin
							tcnt_d = sat_inc(tcnt_q);
							done   = 1'b1;
						end else begin
							pend_v = 1'b1;
							pend_r = mk(K_NUM, tsl_q, tsc_q, tcnt_q, ERR_NONE);
							mode_d = MODE_IDLE;
						end
					end
					MODE_STRING: begin
						if (c == CH_QUOTE) begin
							pend_v = 1'b1;
							pend_r = mk(K_STRING, tsl_q, tsc_q, tcnt_q, ERR_NONE);
							mode_d = MODE_IDLE;
						end else begin
							tcnt_d = sat_inc(tcnt_q);
						end
						done = 1'b1;
					end
					MODE_EQ: begin
						pend_v = 1'b1;
						if (c == CH_EQUALS) begin
							pend_r = mk(K_EQ, tsl_q, tsc_q, POS_TWO, ERR_NONE);
							done   = 1'b1;
						end else begin
							pend_r = mk(K_ASSIGN, tsl_q, tsc_q, POS_ONE, ERR_NONE);
						end
						mode_d = MODE_IDLE;
					end
					MODE_LT: begin
						pend_v = 1'b1;
						if (c == CH_EQUALS) begin
							pend_r = mk(K_LE, tsl_q, tsc_q, POS_TWO, ERR_NONE);
							done   = 1'b1;
						end else begin
							pend_r = mk(K_LE, tsl_q, tsc_q, POS_ONE, ERR_NONE);
						end
						mode_d = MODE_IDLE;
					end
					MODE_AMP: begin
						pend_v = 1'b1;
						if (c == CH_AMP) begin
							pend_r = mk(K_AND, tsl_q, tsc_q, POS_TWO, ERR_NONE);
							mode_d = MODE_IDLE;
							done   = 1'b1;
						end else begin
							pend_r   = mk(K_INT, tsl_q, tsc_q, '0, ERR_UNEXPECTED);
							halt_now = 1'b1;
						end
					end
					default: mode_d = MODE_IDLE;
				endcase

				// Start of a new token, a single-character operator, or a bad byte.
				if (!done && !halt_now) begin
					if (is_space(c)) begin
						mode_d = mode_d;
					end else if (is_digit(c) || is_alpha(c) || c == CH_QUOTE ||
						c == CH_EQUALS || c == CH_LESS || c == CH_AMP) begin
						tsl_d  = line_q;
						tsc_d  = col_q;
						tcnt_d = POS_ONE;
						if (is_digit(c)) begin
							mode_d = MODE_INT;
						end else if (is_alpha(c)) begin
							mode_d        = MODE_WORD;
							prefix_d      = '0;
							prefix_d[7:0] = c;
							too_long_d    = 1'b0;
						end else if (c == CH_QUOTE) begin
							mode_d = MODE_STRING;
							tcnt_d = '0;
						end else if (c == CH_EQUALS) begin
							mode_d = MODE_EQ;
						end else if (c == CH_LESS) begin
							mode_d = MODE_LT;
						end else begin
							mode_d = MODE_AMP;
						end
					end else if (op.hit) begin
						new_v = 1'b1;
						new_r = mk(op.kind, line_q, col_q, POS_ONE, ERR_NONE);
					end else begin
						new_v    = 1'b1;
						new_r    = mk(K_INT, line_q, col_q, '0, ERR_UNEXPECTED);
						halt_now = 1'b1;
					end
				end

				if (c == CH_NEWLINE) begin
					line_d = sat_inc(line_q);
					col_d  = POS_ONE;
				end else begin
					col_d = sat_inc(col_q);
				end
			end
		end

		if (halt_now) mode_d = MODE_HALT;
		if (eof_reset) begin
			mode_d     = MODE_IDLE;
			prefix_d   = '0;
			too_long_d = 1'b0;
			tsl_d      = POS_ONE;
			tsc_d      = POS_ONE;
			tcnt_d     = '0;
			line_d     = POS_ONE;
			col_d      = POS_ONE;
		end
	end

	// Pack: a pending token always leads, the new result follows it.
	always_comb begin
		push_valid = accept && (pend_v || new_v);
		if (pend_v) begin
			push_data.first  = pend_r;
			push_data.second = new_r;
			push_data.two    = new_v;
		end else begin
			push_data.first  = new_r;
			push_data.second = '0;
			push_data.two    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			prefix_q   <= '0;
			too_long_q <= 1'b0;
			tsl_q      <= POS_ONE;
			tsc_q      <= POS_ONE;
			tcnt_q     <= '0;
			line_q     <= POS_ONE;
			col_q      <= POS_ONE;
		end else if (accept) begin
			mode_q     <= mode_d;
			prefix_q   <= prefix_d;
			too_long_q <= too_long_d;
			tsl_q      <= tsl_d;
			tsc_q      <= tsc_d;
			tcnt_q     <= tcnt_d;
			line_q     <= line_d;
			col_q      <= col_d;
		end
	end

endmodule

// File: rtl/core/slx_queue.sv
// Short FIFO of result bundles between the lexer front end and the output stage.
// Uses slx_pkg for the bundle and status types.
`timescale 1ns / 1ps

module slx_queue #(
	parameter int QUEUE_DEPTH = slx_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	input  slx_pkg::bundle_t   push_data,
	input  logic               pop,
	output slx_pkg::q_status_t q_status,
	output slx_pkg::bundle_t   head_data
);
	import slx_pkg::*;

	localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(QUEUE_DEPTH - 1);

	bundle_t             mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
		return (p == LAST_PTR) ? '0 : p + PTR_BITS'(1);
	endfunction

	assign q_status.not_full  = (count_q != CNT_BITS'(QUEUE_DEPTH));
	assign q_status.not_empty = (count_q != '0);
	assign head_data          = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_valid) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_valid) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop) rd_ptr_q <= next_ptr(rd_ptr_q);
			case ({push_valid, pop})
				2'b10:   count_q <= count_q + CNT_BITS'(1);
				2'b01:   count_q <= count_q - CNT_BITS'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/core/slx_back.sv
// Lexer output stage: splits each bundle into single tokens and holds them in an
// output register until the sink takes them. Uses slx_pkg and slx_out_if.
`timescale 1ns / 1ps

module slx_back (
	input  logic               clk,
	input  logic               arst_n,
	input  slx_pkg::q_status_t q_status,
	input  slx_pkg::bundle_t   head_data,
	output logic               pop,
	slx_out_if.source          token_out
);
	import slx_pkg::*;

	logic    valid_q;
	logic    sel_q;
	result_t res_q;
	logic    last_q;
	logic    load;
	logic    last_pick;

	assign load      = q_status.not_empty && (!valid_q || token_out.ready);
	assign last_pick = sel_q || !head_data.two;
	assign pop       = load && last_pick;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				sel_q   <= !last_pick;
			end else if (token_out.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q  <= sel_q ? head_data.second : head_data.first;
			last_q <= last_pick;
		end
	end

	assign token_out.valid        = valid_q;
	assign token_out.token_kind   = 5'(res_q.kind);
	assign token_out.start_line   = res_q.line;
	assign token_out.start_column = res_q.column;
	assign token_out.token_length = res_q.length;
	assign token_out.error_code   = 2'(res_q.err);
	assign token_out.last_of_run  = last_q;

endmodule

// File: rtl/core/source_text_lexer.sv
// Streaming lexer: one source byte per transfer in, one token per transfer out.
// Throughput: one character per cycle, stalling only while the bundle queue is full; a
// character that ends one token and emits another gives two output transfers.
// A token is written into the bundle queue, then loaded into the output register.
// Reset (arst_n low, asynchronous): scanner idle at line 1 column 1, queue and output
// empty. After an error result the scanner halts and drops input until the next reset.
`timescale 1ns / 1ps

module source_text_lexer #(
	parameter int KEYWORD_CHARS = slx_pkg::KEYWORD_CHARS_DEF,
	parameter int POSITION_BITS = slx_pkg::POSITION_BITS_DEF,
	parameter int QUEUE_DEPTH   = slx_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	slx_in_if.sink     char_in,
	slx_out_if.source  token_out
);
	import slx_pkg::*;

	// Front end to queue: up to two results per character, packed as one bundle.
	logic      push_valid;
	bundle_t   push_data;
	// Queue to output stage.
	bundle_t   head_data;
	q_status_t q_status;
	logic      pop;

	// Classify the character, track line and column, build tokens.
	// The front end stalls only when the queue is full.
	slx_front #(
		.KEYWORD_CHARS (KEYWORD_CHARS),
		.POSITION_BITS (POSITION_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_in    (char_in),
		.q_status   (q_status),
		.push_valid (push_valid),
		.push_data  (push_data)
	);

	// Decouple the scanner from output back-pressure.
	slx_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.pop        (pop),
		.q_status   (q_status),
		.head_data  (head_data)
	);

	// Serialize each bundle into single token transfers and mark the last one.
	slx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.head_data (head_data),
		.pop       (pop),
		.token_out (token_out)
	);

endmodule

// File: rtl/core/slx_checker.sv
// Port-level checks for the lexer output channel, bound onto source_text_lexer.
// Uses slx_pkg for kind and error codes.
`timescale 1ns / 1ps

module slx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [4:0]  token_kind,
	input logic [15:0] token_length,
	input logic [1:0]  error_code,
	input logic        last_of_run
);
	import slx_pkg::*;

	// Hold a stalled token.
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("token valid dropped while stalled");

	a_kind_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(token_kind) && $stable(token_length))
		else $error("token payload changed while stalled");

	// An error result is bare and closes its run.
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != 2'(ERR_NONE) |->
		token_kind == 5'(K_INT) && token_length == '0 && last_of_run)
		else $error("malformed error result");

	// EOF has no length and is always last of its run.
	a_eof_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == 5'(K_EOF) |-> token_length == '0 && last_of_run)
		else $error("malformed end-of-source token");

	// Nothing follows a delivered error until reset.
	a_halt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && error_code != 2'(ERR_NONE) |=> !out_valid)
		else $error("token after error result");

endmodule

bind source_text_lexer slx_checker u_slx_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (token_out.valid),
	.out_ready    (token_out.ready),
	.token_kind   (token_out.token_kind),
	.token_length (token_out.token_length),
	.error_code   (token_out.error_code),
	.last_of_run  (token_out.last_of_run)
);
